/* sv/rotated_line_clip_address_gen_unit_defines.svh */
// assertion macros shared by the span clipper checker
`ifndef ROTATED_LINE_CLIP_ADDRESS_GEN_UNIT_DEFINES_SVH
`define ROTATED_LINE_CLIP_ADDRESS_GEN_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define RLC_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the following cycle
`define RLC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

/* sv/rlc_pkg.sv */
// types, constants and helpers shared by the span clipper stages
package rlc_pkg;

  // field widths
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 16;
  localparam int DIM_W    = 11;
  localparam int ADDR_W   = 20;
  localparam int CW       = 19;
  localparam int ROT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // stream payload widths
  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  // register defaults
  localparam int MAX_SIDE_DEFAULT = 1024;
  localparam int RESET_WIDTH      = 320;
  localparam int RESET_HEIGHT     = 240;
  localparam int DIM_MAX          = (1 << DIM_W) - 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

  // rotation codes
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // after length normalisation
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] len;
    logic                 vert;
    logic                 zero;
    logic [COLOR_W-1:0]   color;
  } norm_t;

  // after rotation into native space
  typedef struct packed {
    logic signed [CW-1:0] fixed_c;
    logic signed [CW-1:0] run_s;
    logic signed [CW-1:0] run_e;
    logic                 nvert;
    logic                 zero;
    logic [COLOR_W-1:0]   color;
  } rot_t;

  // after clipping
  typedef struct packed {
    logic               draws;
    logic               row_step;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   count;
    logic [COLOR_W-1:0] color;
  } clip_t;

  // zero-extend a dimension into the signed working width
  function automatic logic signed [CW-1:0] dim_to_s(input logic [DIM_W-1:0] d);
    dim_to_s = $signed({{(CW-DIM_W){1'b0}}, d});
  endfunction

endpackage

/* sv/rlc_norm.sv */
// stage one: unpack a span and turn a negative length into a positive one
module rlc_norm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rlc_pkg::S_TDATA_W-1:0] in_data,
  input  logic [rlc_pkg::S_TUSER_W-1:0] in_user,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rlc_pkg::norm_t              out_data
);
  import rlc_pkg::*;

  logic signed [CW-1:0] sx, sy, sl;
  norm_t                nxt;

  // sign-extend the coordinate fields
  assign sx = {{(CW-COORD_W){in_data[15]}}, in_data[15:0]};
  assign sy = {{(CW-COORD_W){in_data[31]}}, in_data[31:16]};
  assign sl = {{(CW-COORD_W){in_data[47]}}, in_data[47:32]};

  // a negative span becomes the positive span ending at the start point
  always_comb begin
    nxt.x     = sx;
    nxt.y     = sy;
    nxt.len   = sl;
    nxt.vert  = in_user[0];
    nxt.zero  = (sl == '0);
    nxt.color = in_data[63:48];
    if (sl[CW-1]) begin
      if (in_user[0]) begin
        nxt.y = sy + sl + CW'(1);
      end else begin
        nxt.x = sx + sl + CW'(1);
      end
      nxt.len = -sl;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

/* sv/rlc_rotate.sv */
// stage two: map the span through the display rotation
module rlc_rotate (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rlc_pkg::ROT_W-1:0] rotation,
  input  logic [rlc_pkg::DIM_W-1:0] width,
  input  logic [rlc_pkg::DIM_W-1:0] height,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rlc_pkg::norm_t            in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rlc_pkg::rot_t             out_data
);
  import rlc_pkg::*;

  logic signed [CW-1:0] w, h, x, y, len;
  rot_t                 nxt;

  assign w   = dim_to_s(width);
  assign h   = dim_to_s(height);
  assign x   = in_data.x;
  assign y   = in_data.y;
  assign len = in_data.len;

  // fixed coordinate, run start and run end in native space
  always_comb begin
    nxt.zero  = in_data.zero;
    nxt.color = in_data.color;
    unique case ({in_data.vert, rotation})
      {1'b0, ROT_90}: begin
        nxt.nvert = 1'b1; nxt.fixed_c = w - CW'(1) - y;
        nxt.run_s = x;    nxt.run_e = x + len - CW'(1);
      end
      {1'b0, ROT_180}: begin
        nxt.nvert = 1'b0;        nxt.fixed_c = h - CW'(1) - y;
        nxt.run_s = w - x - len; nxt.run_e = w - x - CW'(1);
      end
      {1'b0, ROT_270}: begin
        nxt.nvert = 1'b1;        nxt.fixed_c = y;
        nxt.run_s = h - x - len; nxt.run_e = h - x - CW'(1);
      end
      {1'b0, ROT_0}: begin
        nxt.nvert = 1'b0; nxt.fixed_c = y;
        nxt.run_s = x;    nxt.run_e = x + len - CW'(1);
      end
      {1'b1, ROT_90}: begin
        nxt.nvert = 1'b0;        nxt.fixed_c = x;
        nxt.run_s = w - y - len; nxt.run_e = w - y - CW'(1);
      end
      {1'b1, ROT_180}: begin
        nxt.nvert = 1'b1;        nxt.fixed_c = w - CW'(1) - x;
        nxt.run_s = h - y - len; nxt.run_e = h - y - CW'(1);
      end
      {1'b1, ROT_270}: begin
        nxt.nvert = 1'b0; nxt.fixed_c = h - CW'(1) - x;
        nxt.run_s = y;    nxt.run_e = y + len - CW'(1);
      end
      default: begin
        nxt.nvert = 1'b1; nxt.fixed_c = x;
        nxt.run_s = y;    nxt.run_e = y + len - CW'(1);
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

/* sv/rlc_clip.sv */
// stage three: clip the run to the native frame and pick row and column
module rlc_clip (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rlc_pkg::DIM_W-1:0] width,
  input  logic [rlc_pkg::DIM_W-1:0] height,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rlc_pkg::rot_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rlc_pkg::clip_t            out_data
);
  import rlc_pkg::*;

  logic signed [CW-1:0] lim_fixed, lim_run, sc, ec, cnt;
  logic                 keep;
  clip_t                nxt;

  // fixed coordinate is a column for vertical runs, a row otherwise
  assign lim_fixed = in_data.nvert ? dim_to_s(width) : dim_to_s(height);
  assign lim_run   = in_data.nvert ? dim_to_s(height) : dim_to_s(width);

  assign keep = !in_data.zero
             && !in_data.fixed_c[CW-1] && (in_data.fixed_c < lim_fixed)
             && (in_data.run_s < lim_run) && !in_data.run_e[CW-1];

  // clamp both ends of the run
  assign sc  = in_data.run_s[CW-1] ? '0 : in_data.run_s;
  assign ec  = (in_data.run_e > lim_run - CW'(1)) ? lim_run - CW'(1) : in_data.run_e;
  assign cnt = ec - sc + CW'(1);

  // dropped spans carry zeros apart from the colour
  always_comb begin
    nxt.color = in_data.color;
    if (keep) begin
      nxt.draws    = 1'b1;
      nxt.row_step = in_data.nvert;
      nxt.row      = in_data.nvert ? sc[DIM_W-1:0] : in_data.fixed_c[DIM_W-1:0];
      nxt.col      = in_data.nvert ? in_data.fixed_c[DIM_W-1:0] : sc[DIM_W-1:0];
      nxt.count    = cnt[DIM_W-1:0];
    end else begin
      nxt.draws    = 1'b0;
      nxt.row_step = 1'b0;
      nxt.row      = '0;
      nxt.col      = '0;
      nxt.count    = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

/* sv/rlc_addr.sv */
// stage four: row times stride plus column, packed into the output register
module rlc_addr (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rlc_pkg::DIM_W-1:0]     width,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rlc_pkg::clip_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rlc_pkg::M_TDATA_W-1:0] out_data,
  output logic [rlc_pkg::M_TUSER_W-1:0] out_user
);
  import rlc_pkg::*;

  logic [2*DIM_W-1:0] prod;
  logic [2*DIM_W-1:0] addr;

  // word address of the first pixel, wrapped to the address width
  assign prod = in_data.row * width;
  assign addr = prod + {{DIM_W{1'b0}}, in_data.col};

  assign in_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= {1'b0, in_data.color, in_data.count, addr[ADDR_W-1:0]};
      out_user <= {in_data.row_step, in_data.draws};
    end
  end

endmodule

/* sv/rotated_line_clip_address_gen_unit.sv */
// a span beat is registered in turn by the norm, rotate, clip and addr stages
// throughput: one span per cycle; each stage holds its beat while the next one stalls
// the row times stride multiply in the fourth stage sets the longest path
// reset clears all stage valid bits and loads rotation 0, width 320, height 240
// (all dimensions capped at MAX_SIDE and at DIM_MAX, on reset and when written)
module rotated_line_clip_address_gen_unit #(
  parameter int MAX_SIDE = rlc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlc_pkg::DIM_W-1:0]     cfg_data,
  // span input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x[15:0], start_y[31:16], span_length[47:32], color[63:48]
  input  logic [rlc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // is_vertical[0]
  input  logic [rlc_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // fill descriptor output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // start_address[19:0], pixel_count[30:20], fill_color[46:31], zero pad[47]
  output logic [rlc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // draws[0], row_step[1]
  output logic [rlc_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import rlc_pkg::*;

  localparam int SIDE_CAP = (MAX_SIDE > DIM_MAX) ? DIM_MAX : MAX_SIDE;
  localparam logic [DIM_W-1:0] CAP = DIM_W'(SIDE_CAP);
  localparam logic [DIM_W-1:0] WIDTH_RST =
    DIM_W'((RESET_WIDTH > SIDE_CAP) ? SIDE_CAP : RESET_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RST =
    DIM_W'((RESET_HEIGHT > SIDE_CAP) ? SIDE_CAP : RESET_HEIGHT);

  logic [ROT_W-1:0] rotation;
  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  logic [DIM_W-1:0] dim_sat;

  logic  n_valid, n_ready, r_valid, r_ready, c_valid, c_ready;
  norm_t n_data;
  rot_t  r_data;
  clip_t c_data;

  // configuration registers, dimensions kept saturated
  assign cfg_ready = 1'b1;
  assign dim_sat   = (cfg_data > CAP) ? CAP : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_0;
      width    <= WIDTH_RST;
      height   <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROTATION: rotation <= cfg_data[ROT_W-1:0];
        REG_WIDTH:    width    <= dim_sat;
        REG_HEIGHT:   height   <= dim_sat;
        default: ;
      endcase
    end
  end

  // pipeline
  rlc_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .out_data  (n_data)
  );

  rlc_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .rotation  (rotation),
    .width     (width),
    .height    (height),
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .in_data   (n_data),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  rlc_clip u_clip (
    .clk       (clk),
    .rst       (rst),
    .width     (width),
    .height    (height),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_data   (r_data),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  rlc_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .width     (width),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_data   (c_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

/* sv/rlc_checker.sv */
// port-level checks on the span clipper output, bound to the top level
`include "rotated_line_clip_address_gen_unit_defines.svh"

module rlc_checker #(
  parameter int MAX_SIDE = rlc_pkg::MAX_SIDE_DEFAULT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rlc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [rlc_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import rlc_pkg::*;

  localparam int SIDE_CAP = (MAX_SIDE > DIM_MAX) ? DIM_MAX : MAX_SIDE;
  localparam logic [DIM_W-1:0] CAP = DIM_W'(SIDE_CAP);

  // a dropped span shows zero address, count and step
  `RLC_ASSERT_IMPL(a_drop_zero, clk, rst, (m_axis_tvalid && !m_axis_tuser[0]), ((m_axis_tdata[30:0] == '0) && !m_axis_tuser[1]), "dropped span with nonzero fields")

  // the clipped count never exceeds the largest side
  `RLC_ASSERT_IMPL(a_count_cap, clk, rst, (m_axis_tvalid), (m_axis_tdata[30:20] <= CAP), "pixel count above side limit")

  // a stalled descriptor holds
  `RLC_ASSERT_NEXT(a_hold, clk, rst, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled descriptor changed")

endmodule

bind rotated_line_clip_address_gen_unit rlc_checker #(.MAX_SIDE(MAX_SIDE)) u_rlc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
